// ===== rtl/core/jrsf_pkg.sv =====
// Shared types and constants for the JPEG restart/stuffing framer.
// No dependencies; imported by the framer, its checker and the testbench.
package jrsf_pkg;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_BLOCK = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] STUFF_BYTE  = 8'h00;
    localparam logic [7:0] EOI_CODE    = 8'hD9;
    // RST0..RST7 share the upper five bits; the restart index fills the rest
    localparam logic [4:0] RST_BASE_HI = 5'b11010;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
    } t_result;

endpackage

// ===== rtl/core/jpeg_restart_stuffing_framer.sv =====
// Top level of the JPEG restart/stuffing framer: command decode, marker state
// and a four-entry result queue. Depends on jrsf_pkg.

// Accepts one command item per cycle while o_ready is high and emits the
// composed scan bytes. A data item yields its byte (plus a stuffed 0x00 after
// 0xFF), a block item yields 0xFF RSTn for every block but the first of a
// frame, and an end-of-frame item yields 0xFF 0xD9 with o_frame_last on the
// 0xD9 byte. Results are produced in the cycle of acceptance into a four-byte
// queue, so items that make one byte flow at one per cycle while i_ready is
// high; two-byte items are limited by the output port. The input stalls only
// while the queue holds more than two bytes. With an empty queue, the first
// byte of an accepted item is valid at the output in the next cycle.
module jpeg_restart_stuffing_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_last
);
    import jrsf_pkg::*;

    t_result         r_queue [QUEUE_DEPTH];
    logic [QAW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QAW:0]    r_count, n_count;
    logic            r_seen_first, n_seen_first;
    logic [2:0]      r_rst_idx, n_rst_idx;

    logic            in_acc;
    logic            out_acc;
    logic [1:0]      num_res;
    t_result         res0, res1;
    t_opcode         op;

    assign op      = t_opcode'(i_opcode);
    assign o_ready = (r_count <= (QAW+1)'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign o_out_byte   = r_queue[r_rd_ptr].out_byte;
    assign o_frame_last = r_queue[r_rd_ptr].frame_last;

    always_comb begin
        num_res      = 2'd0;
        res0         = '{out_byte: MARK_PREFIX, frame_last: 1'b0};
        res1         = '{out_byte: STUFF_BYTE, frame_last: 1'b0};
        n_seen_first = r_seen_first;
        n_rst_idx    = r_rst_idx;
        unique case (op)
            OP_DATA: begin
                res0.out_byte = i_data_byte;
                num_res       = (i_data_byte == MARK_PREFIX) ? 2'd2 : 2'd1;
            end
            OP_BLOCK: begin
                if (r_seen_first) begin
                    res1.out_byte = {RST_BASE_HI, r_rst_idx};
                    num_res       = 2'd2;
                    n_rst_idx     = r_rst_idx + 3'd1;
                end else begin
                    n_seen_first = 1'b1;
                end
            end
            OP_END: begin
                res1         = '{out_byte: EOI_CODE, frame_last: 1'b1};
                num_res      = 2'd2;
                n_seen_first = 1'b0;
                n_rst_idx    = 3'd0;
            end
            default: begin
                // unused opcode: no output, state kept
            end
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (in_acc) begin
            n_wr_ptr = r_wr_ptr + QAW'(num_res);
            n_count  = n_count + (QAW+1)'(num_res);
        end
        if (out_acc) begin
            n_rd_ptr = r_rd_ptr + QAW'(1);
            n_count  = n_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_seen_first <= 1'b0;
            r_rst_idx    <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            if (in_acc) begin
                r_seen_first <= n_seen_first;
                r_rst_idx    <= n_rst_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (num_res != 2'd0) begin
                r_queue[r_wr_ptr] <= res0;
            end
            if (num_res == 2'd2) begin
                r_queue[r_wr_ptr + QAW'(1)] <= res1;
            end
        end
    end

endmodule

// ===== rtl/core/jrsf_checker.sv =====
// Port-level checks for the JPEG restart/stuffing framer, bound to the top.
// Depends on jrsf_pkg and jpeg_restart_stuffing_framer.
module jrsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_opcode,
    input logic [7:0] i_data_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_frame_last
);
    import jrsf_pkg::*;

    // the end-of-image flag only ever rides on the 0xD9 byte
    a_last_is_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> (o_out_byte == EOI_CODE))
        else $error("frame_last on a byte other than EOI");

    // input stalls only while results are queued
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty queue");

    // reset empties the queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_out_byte) && $stable(o_frame_last)))
        else $error("stalled result changed");

    // a waiting input item keeps valid and payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=>
            (i_valid && $stable(i_opcode) && $stable(i_data_byte)))
        else $error("stalled input item changed");

endmodule

bind jpeg_restart_stuffing_framer jrsf_checker u_jrsf_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for jpeg_restart_stuffing_framer: directed and random
// command items, scoreboard-based byte checking. Depends on jrsf_pkg and the framer RTL.
`timescale 1ns / 1ps

import jrsf_pkg::*;

class scan_byte_scoreboard;
    t_result    expected_bytes[$];
    bit         block_started;
    logic [2:0] rst_num;
    int         mismatches;

    function new();
        block_started = 1'b0;
        rst_num       = 3'd0;
        mismatches    = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    // Print one line per mismatch (first hundred only) and count them all
    task report(string msg);
        if (mismatches < 100) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Work out the bytes an accepted command item produces
    function void note_command(t_opcode op, logic [7:0] data);
        case (op)
            OP_DATA: begin
                expected_bytes.push_back('{out_byte: data, frame_last: 1'b0});
                if (data == MARK_PREFIX) begin
                    expected_bytes.push_back('{out_byte: STUFF_BYTE, frame_last: 1'b0});
                end
            end
            OP_BLOCK: begin
                if (block_started) begin
                    expected_bytes.push_back('{out_byte: MARK_PREFIX, frame_last: 1'b0});
                    expected_bytes.push_back('{out_byte: {RST_BASE_HI, rst_num},
                                               frame_last: 1'b0});
                    rst_num = rst_num + 3'd1;
                end else begin
                    block_started = 1'b1;
                end
            end
            OP_END: begin
                expected_bytes.push_back('{out_byte: MARK_PREFIX, frame_last: 1'b0});
                expected_bytes.push_back('{out_byte: EOI_CODE, frame_last: 1'b1});
                block_started = 1'b0;
                rst_num       = 3'd0;
            end
            default: ;
        endcase
    endfunction

    task check_byte(logic [7:0] out_byte, logic frame_last);
        t_result exp_r;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last=%0b", out_byte, frame_last));
        end else begin
            exp_r = expected_bytes.pop_front();
            if (out_byte !== exp_r.out_byte) begin
                report($sformatf("out_byte %02h, expected %02h", out_byte, exp_r.out_byte));
            end
            if (frame_last !== exp_r.frame_last) begin
                report($sformatf("frame_last %0b, expected %0b on byte %02h",
                                 frame_last, exp_r.frame_last, exp_r.out_byte));
            end
        end
    endtask
endclass

module tb;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 2000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_opcode;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_frame_last;

    scan_byte_scoreboard sb;
    int burst_left;
    int cmd_count;
    int idle_cycles;
    int rx_mode;
    int rx_phase;

    jpeg_restart_stuffing_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_last(o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = OP_NONE;
        i_data_byte = 8'h00;
        i_ready     = 1'b0;
        sb          = new();
        burst_left  = 0;
        cmd_count   = 0;
        idle_cycles = 0;
        rx_mode     = 0;
        rx_phase    = 0;
    end

    // Receiver: switches its stall pattern, picked at random from five modes, as rx_phase advances
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (rx_phase % 64 == 63) begin
                rx_mode <= $urandom_range(0, 4);
            end
            case (rx_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                2:       i_ready <= ($urandom_range(0, 3) == 0);
                3:       i_ready <= rx_phase[0];
                default: i_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_byte(o_out_byte, o_frame_last);
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 8) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 8);
        return $urandom_range(10, 20);
    endfunction

    task automatic send_item(t_opcode op, logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = pick_gap();
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 32);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        sb.note_command(op, data);
        burst_left--;
        if (op != OP_NONE) cmd_count++;
    endtask

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 5) == 0) return MARK_PREFIX;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_directed();
        send_item(OP_END, 8'h00);         // empty frame
        send_item(OP_DATA, 8'h00);        // data before any block
        send_item(OP_DATA, 8'hFF);
        send_item(OP_NONE, 8'hFF);        // unused opcode, ignored
        send_item(OP_BLOCK, 8'hFF);       // first block: no marker
        send_item(OP_DATA, 8'h7F);
        repeat (9) send_item(OP_BLOCK, 8'h00);  // RST0..RST7 and wrap to RST0
        send_item(OP_DATA, 8'h80);
        send_item(OP_END, 8'hFF);
        send_item(OP_BLOCK, 8'h00);
        send_item(OP_BLOCK, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_END, 8'h00);
    endtask

    task automatic run_random();
        int n_blocks;
        int n_data;
        int start_count;
        start_count = cmd_count;
        while (cmd_count - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: raw random commands
                repeat ($urandom_range(1, 4))
                    send_item(t_opcode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                n_blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12)
                                                       : $urandom_range(1, 5);
                for (int b = 0; b < n_blocks; b++) begin
                    send_item(OP_BLOCK, 8'($urandom_range(0, 255)));
                    n_data = $urandom_range(0, 6);
                    for (int k = 0; k < n_data; k++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_item(OP_NONE, 8'($urandom_range(0, 255)));
                        end
                        send_item(OP_DATA, pick_data());
                    end
                end
                // some frames run on without an end marker
                if ($urandom_range(0, 7) != 0) begin
                    send_item(OP_END, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() > 0) begin
            sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
